// ===== hdl/cbrf_pkg.sv =====
package cbrf_pkg;

  localparam int POS_W     = 24;
  localparam int TOL_W     = 21;
  localparam int STATUS_W  = 3;
  localparam int STEPS_W   = 13;
  localparam logic [STEPS_W-1:0] STEPS_MAX = '1;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_BISECT_DEF = 64;
  localparam int MAX_SCAN_DEF   = 4032;

  localparam int PC_W = 6;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENDPOINT = 3'd0,
    ST_SCAN     = 3'd1,
    ST_BISECT   = 3'd2,
    ST_NONE     = 3'd3,
    ST_LIMIT    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQ,
    OP_CUBE,
    OP_POLY,
    OP_FA_XB,
    OP_SCAN,
    OP_XB,
    OP_MID,
    OP_UPDATE,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_F_ZERO,
    C_SIGN_DIFF,
    C_SCAN_LIM,
    C_B_LE_A,
    C_F_LE_TOL,
    C_BIS_DONE,
    C_BIS_LIM
  } cond_t;

  typedef enum logic [1:0] {
    W_NONE,
    W_IN,
    W_OUT
  } wait_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_A,
    SRC_B,
    SRC_X
  } src_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    wait_t            wt;
    src_t             src;
    status_t          status;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  localparam logic [PC_W-1:0] A_IDLE    = 6'd0;
  localparam logic [PC_W-1:0] A_SQ_A    = 6'd1;
  localparam logic [PC_W-1:0] A_CUBE_A  = 6'd2;
  localparam logic [PC_W-1:0] A_POLY_A  = 6'd3;
  localparam logic [PC_W-1:0] A_FA      = 6'd4;
  localparam logic [PC_W-1:0] A_SQ_B    = 6'd5;
  localparam logic [PC_W-1:0] A_CUBE_B  = 6'd6;
  localparam logic [PC_W-1:0] A_POLY_B  = 6'd7;
  localparam logic [PC_W-1:0] A_FB_ZERO = 6'd8;
  localparam logic [PC_W-1:0] A_FB_SIGN = 6'd9;
  localparam logic [PC_W-1:0] A_SCAN    = 6'd10;
  localparam logic [PC_W-1:0] A_SC_STEP = 6'd11;
  localparam logic [PC_W-1:0] A_SC_XB   = 6'd12;
  localparam logic [PC_W-1:0] A_SQ_S    = 6'd13;
  localparam logic [PC_W-1:0] A_CUBE_S  = 6'd14;
  localparam logic [PC_W-1:0] A_POLY_S  = 6'd15;
  localparam logic [PC_W-1:0] A_SC_TOL  = 6'd16;
  localparam logic [PC_W-1:0] A_SC_SIGN = 6'd17;
  localparam logic [PC_W-1:0] A_SC_LOOP = 6'd18;
  localparam logic [PC_W-1:0] A_BIS     = 6'd19;
  localparam logic [PC_W-1:0] A_SQ_M    = 6'd20;
  localparam logic [PC_W-1:0] A_CUBE_M  = 6'd21;
  localparam logic [PC_W-1:0] A_POLY_M  = 6'd22;
  localparam logic [PC_W-1:0] A_BI_DONE = 6'd23;
  localparam logic [PC_W-1:0] A_BI_LIM  = 6'd24;
  localparam logic [PC_W-1:0] A_BI_UPD  = 6'd25;
  localparam logic [PC_W-1:0] A_E_A     = 6'd26;
  localparam logic [PC_W-1:0] A_E_B     = 6'd27;
  localparam logic [PC_W-1:0] A_E_LIMB  = 6'd28;
  localparam logic [PC_W-1:0] A_E_NONE  = 6'd29;
  localparam logic [PC_W-1:0] A_E_SCAN  = 6'd30;
  localparam logic [PC_W-1:0] A_E_BIS   = 6'd31;
  localparam logic [PC_W-1:0] A_E_LIMX  = 6'd32;

  function automatic ctrl_t uop(input op_t o, input cond_t c, input logic [PC_W-1:0] t);
    ctrl_t w;
    w = '{op: o, cond: c, wt: W_NONE, src: SRC_ZERO, status: ST_ENDPOINT, target: t};
    return w;
  endfunction

  function automatic ctrl_t uemit(input src_t s, input status_t st);
    ctrl_t w;
    w = '{op: OP_EMIT, cond: C_ALWAYS, wt: W_OUT, src: s, status: st, target: A_IDLE};
    return w;
  endfunction

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      A_IDLE: begin
        w = uop(OP_LOAD, C_NEVER, A_IDLE);
        w.wt = W_IN;
      end
      A_SQ_A:    w = uop(OP_SQ,     C_NEVER,     A_IDLE);
      A_CUBE_A:  w = uop(OP_CUBE,   C_NEVER,     A_IDLE);
      A_POLY_A:  w = uop(OP_POLY,   C_NEVER,     A_IDLE);
      A_FA:      w = uop(OP_FA_XB,  C_F_ZERO,    A_E_A);
      A_SQ_B:    w = uop(OP_SQ,     C_NEVER,     A_IDLE);
      A_CUBE_B:  w = uop(OP_CUBE,   C_NEVER,     A_IDLE);
      A_POLY_B:  w = uop(OP_POLY,   C_NEVER,     A_IDLE);
      A_FB_ZERO: w = uop(OP_NOP,    C_F_ZERO,    A_E_B);
      A_FB_SIGN: w = uop(OP_NOP,    C_SIGN_DIFF, A_BIS);
      A_SCAN:    w = uop(OP_NOP,    C_SCAN_LIM,  A_E_LIMB);
      A_SC_STEP: w = uop(OP_SCAN,   C_NEVER,     A_IDLE);
      A_SC_XB:   w = uop(OP_XB,     C_B_LE_A,    A_E_NONE);
      A_SQ_S:    w = uop(OP_SQ,     C_NEVER,     A_IDLE);
      A_CUBE_S:  w = uop(OP_CUBE,   C_NEVER,     A_IDLE);
      A_POLY_S:  w = uop(OP_POLY,   C_NEVER,     A_IDLE);
      A_SC_TOL:  w = uop(OP_NOP,    C_F_LE_TOL,  A_E_SCAN);
      A_SC_SIGN: w = uop(OP_NOP,    C_SIGN_DIFF, A_BIS);
      A_SC_LOOP: w = uop(OP_NOP,    C_ALWAYS,    A_SCAN);
      A_BIS:     w = uop(OP_MID,    C_NEVER,     A_IDLE);
      A_SQ_M:    w = uop(OP_SQ,     C_NEVER,     A_IDLE);
      A_CUBE_M:  w = uop(OP_CUBE,   C_NEVER,     A_IDLE);
      A_POLY_M:  w = uop(OP_POLY,   C_NEVER,     A_IDLE);
      A_BI_DONE: w = uop(OP_NOP,    C_BIS_DONE,  A_E_BIS);
      A_BI_LIM:  w = uop(OP_NOP,    C_BIS_LIM,   A_E_LIMX);
      A_BI_UPD:  w = uop(OP_UPDATE, C_ALWAYS,    A_BIS);
      A_E_A:     w = uemit(SRC_A,    ST_ENDPOINT);
      A_E_B:     w = uemit(SRC_B,    ST_ENDPOINT);
      A_E_LIMB:  w = uemit(SRC_B,    ST_LIMIT);
      A_E_NONE:  w = uemit(SRC_ZERO, ST_NONE);
      A_E_SCAN:  w = uemit(SRC_B,    ST_SCAN);
      A_E_BIS:   w = uemit(SRC_X,    ST_BISECT);
      A_E_LIMX:  w = uemit(SRC_X,    ST_LIMIT);
      default:   w = uop(OP_NOP,    C_ALWAYS,    A_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/cbrf_in_if.sv =====
interface cbrf_in_if import cbrf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] left_end;
  logic signed [POS_W-1:0] right_end;
  logic [TOL_W-1:0]        tolerance;

  modport source (output valid, left_end, right_end, tolerance, input ready);
  modport sink (input valid, left_end, right_end, tolerance, output ready);
endinterface

// ===== hdl/cbrf_out_if.sv =====
interface cbrf_out_if import cbrf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] root;
  logic [STATUS_W-1:0]     status;
  logic [STEPS_W-1:0]      steps_used;

  modport source (output valid, root, status, steps_used, input ready);
  modport sink (input valid, root, status, steps_used, output ready);
endinterface

// ===== hdl/cubic_bisection_root_finder.sv =====
// Root finder for f(x) = x^3 - 9x + 3 in signed fixed point (FRAC_BITS fraction bits).
// in_ch carries an interval [left_end, right_end] and a tolerance; out_ch returns one
// result per item: root, status and steps_used. Both channels use valid/ready and a
// transfer happens when both are high at a rising edge of clk.
// A microcode ROM steps a single datapath; each cubic is evaluated in square, cube
// and polynomial steps, with square and cube on one shared multiplier. The result
// register is loaded in an emit step after the last test, and the next input
// transfer can follow once the sequencer is back in idle.
// One item is worked on at a time. in_ch.ready is high while the sequencer is idle,
// which includes the time a finished result waits in the output register.
// If out_ch stalls, the next result holds in its emit step until the register frees.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_ch.valid;
// no state is kept between items.
module cubic_bisection_root_finder import cbrf_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_BISECT = MAX_BISECT_DEF,
  parameter int MAX_SCAN   = MAX_SCAN_DEF
) (
  input logic       clk,
  input logic       rst_n,
  cbrf_in_if.sink   in_ch,
  cbrf_out_if.source out_ch
);

  localparam int XW      = POS_W;
  localparam int BW      = XW + 4;
  localparam int SQ_W    = 2 * XW - FRAC_BITS;
  localparam int PROD_W  = SQ_W + XW;
  localparam int CU_W    = PROD_W - FRAC_BITS;
  localparam int F_BASE  = (CU_W > XW + 4) ? CU_W : XW + 4;
  localparam int F_W     = F_BASE + 2;
  localparam int STEP_W  = $clog2(MAX_SCAN + MAX_BISECT + 1);
  localparam int N_W     = $clog2(MAX_BISECT + 1);
  localparam int SAT_W   = (STEP_W > STEPS_W) ? STEP_W : STEPS_W;
  localparam logic signed [F_W-1:0] THREE_Q = F_W'(3) <<< FRAC_BITS;

  logic [PC_W-1:0]          pc_r, pc_nxt;
  logic signed [BW-1:0]     a_r, b_r;
  logic signed [XW-1:0]     x_r;
  logic signed [F_W-1:0]    fa_r, f_r;
  logic signed [PROD_W-1:0] p_r;
  logic [TOL_W-1:0]         tol_r;
  logic [STEP_W-1:0]        steps_r;
  logic [N_W-1:0]           n_r;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [XW-1:0]     root_r;
  logic [STATUS_W-1:0]      status_r;
  logic [STEPS_W-1:0]       steps_used_r;

  ctrl_t                    cw;
  logic                     in_acc, out_free, hold, cond_true;

  logic signed [SQ_W-1:0]   mul_a;
  logic signed [PROD_W-1:0] p_shift, mul_p;
  logic signed [SQ_W-1:0]   sq_v;
  logic signed [CU_W-1:0]   cu_v;
  logic signed [F_W-1:0]    x_ext, nine_x, f_new;
  logic [F_W-1:0]           f_mag;
  logic [TOL_W+3:0]         ten_tol;
  logic signed [BW-1:0]     b_scan;
  logic signed [BW:0]       ab_sum, ab_half, ab_diff;
  logic [BW:0]              diff_mag;
  logic                     f_zero, sign_diff, f_le_tol, w_le_tol;
  logic [SAT_W-1:0]         steps_ext;
  logic [STEPS_W-1:0]       steps_sat;
  logic signed [XW-1:0]     root_sel;

  assign cw       = ucode(pc_r);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready       = (pc_r == A_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.root       = root_r;
  assign out_ch.status     = status_r;
  assign out_ch.steps_used = steps_used_r;

  // cubic datapath
  assign p_shift = p_r >>> FRAC_BITS;
  assign sq_v    = $signed(p_shift[SQ_W-1:0]);
  assign mul_a   = (cw.op == OP_CUBE) ? sq_v : SQ_W'(x_r);
  assign mul_p   = mul_a * x_r;
  assign cu_v    = $signed(p_shift[CU_W-1:0]);
  assign x_ext   = F_W'(x_r);
  assign nine_x  = (x_ext <<< 3) + x_ext;
  assign f_new   = F_W'(cu_v) - nine_x + THREE_Q;

  // interval datapath
  assign ten_tol  = ((TOL_W + 4)'(tol_r) << 3) + ((TOL_W + 4)'(tol_r) << 1);
  assign b_scan   = b_r - $signed(BW'(ten_tol));
  assign ab_sum   = (BW + 1)'(a_r) + (BW + 1)'(b_r);
  assign ab_half  = ab_sum >>> 1;
  assign ab_diff  = (BW + 1)'(b_r) - (BW + 1)'(a_r);
  assign diff_mag = ab_diff[BW] ? -ab_diff : ab_diff;
  assign f_mag    = f_r[F_W-1] ? -f_r : f_r;

  assign f_zero    = (f_r == '0);
  assign sign_diff = fa_r[F_W-1] ^ f_r[F_W-1];
  assign f_le_tol  = (f_mag <= F_W'(tol_r));
  assign w_le_tol  = (diff_mag <= (BW + 1)'(tol_r));

  assign steps_ext = SAT_W'(steps_r);
  assign steps_sat = (steps_ext > SAT_W'(STEPS_MAX)) ? STEPS_MAX : steps_ext[STEPS_W-1:0];

  always_comb begin
    unique case (cw.src)
      SRC_ZERO: root_sel = '0;
      SRC_A:    root_sel = a_r[XW-1:0];
      SRC_B:    root_sel = b_r[XW-1:0];
      SRC_X:    root_sel = x_r;
    endcase
  end

  always_comb begin
    unique case (cw.wt)
      W_IN:    hold = !in_acc;
      W_OUT:   hold = !out_free;
      default: hold = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_F_ZERO:    cond_true = f_zero;
      C_SIGN_DIFF: cond_true = sign_diff;
      C_SCAN_LIM:  cond_true = (steps_r >= STEP_W'(MAX_SCAN));
      C_B_LE_A:    cond_true = (b_r <= a_r);
      C_F_LE_TOL:  cond_true = f_le_tol;
      C_BIS_DONE:  cond_true = f_zero || (f_le_tol && w_le_tol);
      C_BIS_LIM:   cond_true = (n_r >= N_W'(MAX_BISECT));
      default:     cond_true = 1'b0;
    endcase
  end

  always_comb begin
    priority if (hold) begin
      pc_nxt = pc_r;
    end else if (cond_true) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_comb begin
    priority if (!hold && cw.op == OP_EMIT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= A_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      unique case (cw.op)
        OP_NOP: ;
        OP_LOAD: begin
          a_r     <= BW'(in_ch.left_end);
          b_r     <= BW'(in_ch.right_end);
          x_r     <= in_ch.left_end;
          tol_r   <= in_ch.tolerance;
          steps_r <= '0;
          n_r     <= '0;
        end
        OP_SQ:   p_r <= mul_p;
        OP_CUBE: p_r <= mul_p;
        OP_POLY: f_r <= f_new;
        OP_FA_XB: begin
          fa_r <= f_r;
          x_r  <= b_r[XW-1:0];
        end
        OP_SCAN: begin
          b_r     <= b_scan;
          steps_r <= steps_r + STEP_W'(1);
        end
        OP_XB:  x_r <= b_r[XW-1:0];
        OP_MID: x_r <= ab_half[XW-1:0];
        OP_UPDATE: begin
          if (sign_diff) begin
            b_r <= BW'(x_r);
          end else begin
            a_r  <= BW'(x_r);
            fa_r <= f_r;
          end
          steps_r <= steps_r + STEP_W'(1);
          n_r     <= n_r + N_W'(1);
        end
        OP_EMIT: begin
          root_r       <= root_sel;
          status_r     <= cw.status;
          steps_used_r <= steps_sat;
        end
        default: ;
      endcase
    end
  end

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r != A_IDLE |-> steps_r <= STEP_W'(MAX_SCAN + MAX_BISECT))
    else $error("step count beyond scan and bisection limits");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r != A_IDLE |-> n_r <= N_W'(MAX_BISECT))
    else $error("bisection count beyond limit");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> pc_r == A_SQ_A)
    else $error("sequencer did not start after input transfer");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cw.op == OP_EMIT))
    else $error("result raised outside an emit step");

  a_endpoint_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_ENDPOINT |-> steps_used_r == '0)
    else $error("endpoint root reported with nonzero steps");

endmodule
